FILE: design/hngc_pkg.sv
// Shared types and constants for the high-pass / noise-gate chain.
// Holds the control-word layout, register indexes and the step program ROM.
// No dependencies.
package hngc_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_ENABLES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HP_B0         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HP_A1         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HP_A2         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESH_RECIP  = 3'd7;

    localparam int ENABLES_W = 2;
    localparam int HP_BIT    = 0;
    localparam int GATE_BIT  = 1;

    // Fixed-point widths of the gate stage
    localparam int WEIGHT_W  = 16;
    localparam int RECIP_W   = 32;
    localparam int GAIN_FRAC = 16;
    localparam int RATIO_W   = 17;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

    // Multiplier A operand holds the unsigned reciprocal plus a sign bit
    localparam int MUL_A_W = RECIP_W + 1;

    // Program steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_HP_B0X     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_HP_B1X1    = 5'd1;
    localparam logic [STEP_W-1:0] STEP_HP_B2X2    = 5'd2;
    localparam logic [STEP_W-1:0] STEP_HP_A1Y1    = 5'd3;
    localparam logic [STEP_W-1:0] STEP_HP_A2Y2    = 5'd4;
    localparam logic [STEP_W-1:0] STEP_HP_SUM     = 5'd5;
    localparam logic [STEP_W-1:0] STEP_HP_WB      = 5'd6;
    localparam logic [STEP_W-1:0] STEP_GATE_DIFF  = 5'd7;
    localparam logic [STEP_W-1:0] STEP_ENV_MUL    = 5'd8;
    localparam logic [STEP_W-1:0] STEP_ENV_UPD    = 5'd9;
    localparam logic [STEP_W-1:0] STEP_RATIO_MUL  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_RATIO      = 5'd11;
    localparam logic [STEP_W-1:0] STEP_GAIN_MUL   = 5'd12;
    localparam logic [STEP_W-1:0] STEP_GAIN       = 5'd13;
    localparam logic [STEP_W-1:0] STEP_SCALE_MUL  = 5'd14;
    localparam logic [STEP_W-1:0] STEP_SCALE      = 5'd15;
    localparam logic [STEP_W-1:0] STEP_DONE       = 5'd16;

    typedef enum logic [2:0] {
        A_B0, A_B0X2, A_A1, A_A2, A_WEIGHT, A_RECIP, A_RATIO
    } mul_a_sel_t;

    typedef enum logic [2:0] {
        B_X, B_P1, B_P2, B_O1, B_O2, B_DIFF, B_ENV, B_RATIO
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        OP_NONE, OP_FILT_WB, OP_DIFF, OP_ENV, OP_RATIO, OP_GAIN, OP_SCALE, OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        JMP_NEVER, JMP_NO_HP, JMP_NO_GATE, JMP_NOT_BELOW
    } jump_t;

    typedef struct packed {
        mul_a_sel_t        a_sel;
        mul_b_sel_t        b_sel;
        acc_op_t           acc_op;
        dp_op_t            dp_op;
        jump_t             jump;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic   run;
        ucode_t word;
    } ctrl_t;

    typedef struct packed {
        logic hp_en;
        logic gate_en;
        logic env_below;
    } flags_t;

    // Program ROM: the multiplier issued in a step is consumed by the next step.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w.a_sel  = A_B0;
        w.b_sel  = B_X;
        w.acc_op = ACC_HOLD;
        w.dp_op  = OP_NONE;
        w.jump   = JMP_NEVER;
        w.target = STEP_HP_B0X;
        unique case (step)
            STEP_HP_B0X: begin
                w.jump   = JMP_NO_HP;
                w.target = STEP_GATE_DIFF;
            end
            STEP_HP_B1X1: begin
                w.a_sel  = A_B0X2;
                w.b_sel  = B_P1;
                w.acc_op = ACC_LOAD;
            end
            STEP_HP_B2X2: begin
                w.b_sel  = B_P2;
                w.acc_op = ACC_SUB;
            end
            STEP_HP_A1Y1: begin
                w.a_sel  = A_A1;
                w.b_sel  = B_O1;
                w.acc_op = ACC_ADD;
            end
            STEP_HP_A2Y2: begin
                w.a_sel  = A_A2;
                w.b_sel  = B_O2;
                w.acc_op = ACC_SUB;
            end
            STEP_HP_SUM: begin
                w.acc_op = ACC_SUB;
            end
            STEP_HP_WB: begin
                w.dp_op = OP_FILT_WB;
            end
            STEP_GATE_DIFF: begin
                w.dp_op  = OP_DIFF;
                w.jump   = JMP_NO_GATE;
                w.target = STEP_DONE;
            end
            STEP_ENV_MUL: begin
                w.a_sel = A_WEIGHT;
                w.b_sel = B_DIFF;
            end
            STEP_ENV_UPD: begin
                w.dp_op = OP_ENV;
            end
            STEP_RATIO_MUL: begin
                w.a_sel  = A_RECIP;
                w.b_sel  = B_ENV;
                w.jump   = JMP_NOT_BELOW;
                w.target = STEP_DONE;
            end
            STEP_RATIO: begin
                w.dp_op = OP_RATIO;
            end
            STEP_GAIN_MUL: begin
                w.a_sel = A_RATIO;
                w.b_sel = B_RATIO;
            end
            STEP_GAIN: begin
                w.dp_op = OP_GAIN;
            end
            STEP_SCALE_MUL: begin
                w.a_sel = A_RATIO;
                w.b_sel = B_X;
            end
            STEP_SCALE: begin
                w.dp_op = OP_SCALE;
            end
            STEP_DONE: begin
                w.dp_op = OP_OUT;
            end
            default: begin
                w.dp_op = OP_OUT;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: design/hngc_seq.sv
// Step sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on hngc_pkg.
module hngc_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         out_free,
    input  hngc_pkg::flags_t             flags,
    output hngc_pkg::ctrl_t              ctrl,
    output logic                         idle
);

    logic                          busy_reg, busy_next;
    logic [hngc_pkg::STEP_W-1:0]   pc_reg, pc_next;
    hngc_pkg::ucode_t              word;
    logic                          stall;
    logic                          take;

    always_comb begin
        word  = hngc_pkg::ucode_rom(pc_reg);
        // hold on the final step until the output register can take the beat
        stall = (word.dp_op == hngc_pkg::OP_OUT) && !out_free;
        case (word.jump)
            hngc_pkg::JMP_NEVER:     take = 1'b0;
            hngc_pkg::JMP_NO_HP:     take = !flags.hp_en;
            hngc_pkg::JMP_NO_GATE:   take = !flags.gate_en;
            hngc_pkg::JMP_NOT_BELOW: take = !flags.env_below;
            default:                 take = 1'b0;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start) begin
            busy_next = 1'b1;
            pc_next   = hngc_pkg::STEP_HP_B0X;
        end else if (busy_reg && !stall) begin
            if (word.dp_op == hngc_pkg::OP_OUT) begin
                busy_next = 1'b0;
            end else if (take) begin
                pc_next = word.target;
            end else begin
                pc_next = pc_reg + hngc_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= hngc_pkg::STEP_HP_B0X;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctrl.run  = busy_reg && !stall;
    assign ctrl.word = word;
    assign idle      = !busy_reg;

`ifndef NO_ASSERTIONS
    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg <= hngc_pkg::STEP_DONE))
        else $error("step counter left the program");
`endif

endmodule

FILE: design/hngc_dp.sv
// Datapath: configuration registers, filter and envelope state, one shared
// multiplier with product register, accumulator and step operations.
// Depends on hngc_pkg.
module hngc_dp #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [hngc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hngc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 start,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    input  hngc_pkg::ctrl_t                      ctrl,
    output hngc_pkg::flags_t                     flags,
    output logic signed [SAMPLE_WIDTH-1:0]       sample,
    output logic                                 active
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COEF_WIDTH;
    localparam int FRAC_C = CW - 2;
    localparam int FRAC_S = SW - 1;
    localparam int RW     = hngc_pkg::RATIO_W;
    localparam int AW     = hngc_pkg::MUL_A_W;
    localparam int BW     = (SW + 1 > RW + 1) ? SW + 1 : RW + 1;
    localparam int PW     = AW + BW;
    localparam int ACC_W  = CW + SW + 3;

    localparam logic signed [ACC_W-1:0] FILT_HALF  = ACC_W'(1) <<< (FRAC_C - 1);
    localparam logic signed [PW-1:0]    HALF16     = PW'(1) <<< (hngc_pkg::GAIN_FRAC - 1);
    localparam logic signed [PW-1:0]    RATIO_HALF = PW'(1) <<< (FRAC_S - 1);
    localparam logic signed [PW-1:0]    RATIO_CAP  = PW'(hngc_pkg::RATIO_ONE);
    localparam logic signed [PW-1:0]    SAT_MAX    = PW'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [PW-1:0]    SAT_MIN    = ~SAT_MAX;

    function automatic logic signed [SW-1:0] sat_fn(input logic signed [PW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[SW-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[SW-1:0];
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [hngc_pkg::ENABLES_W-1:0]  enables_reg;
    logic [CW-2:0]                   b0_reg;
    logic signed [CW-1:0]            a1_reg;
    logic signed [CW-1:0]            a2_reg;
    logic [hngc_pkg::WEIGHT_W-1:0]   attack_reg;
    logic [hngc_pkg::WEIGHT_W-1:0]   release_reg;
    logic [SW-2:0]                   thr_reg;
    logic [hngc_pkg::RECIP_W-1:0]    recip_reg;

    // Filter and envelope state
    logic signed [SW-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic signed [SW-1:0] o1_reg, o1_next, o2_reg, o2_next;
    logic [SW-1:0]        env_reg, env_next;

    // Working registers
    logic signed [SW-1:0]    x_reg, x_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic [SW-1:0]           diff_reg, diff_next;
    logic                    rise_reg, rise_next;
    logic [RW-1:0]           ratio_reg, ratio_next;
    logic                    active_reg, active_next;

    // Operand and step signals
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [ACC_W-1:0] acc_prod;
    logic signed [ACC_W-1:0] filt_rnd;
    logic signed [ACC_W-1:0] filt_sh;
    logic signed [SW-1:0]    filt_y;
    logic [SW-1:0]           x_bits;
    logic [SW-1:0]           mag;
    logic                    mag_above;
    logic signed [PW-1:0]    prod_half;
    logic [SW-1:0]           env_step;
    logic signed [PW-1:0]    ratio_rnd;
    logic signed [PW-1:0]    ratio_sh;
    logic [RW-1:0]           ratio_val;
    logic signed [PW-1:0]    scale_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enables_reg <= '0;
            b0_reg      <= {1'b1, {FRAC_C{1'b0}}};
            a1_reg      <= '0;
            a2_reg      <= '0;
            attack_reg  <= '1;
            release_reg <= '1;
            thr_reg     <= '0;
            recip_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hngc_pkg::REG_STAGE_ENABLES:
                    enables_reg <= cfg_wdata[hngc_pkg::ENABLES_W-1:0];
                hngc_pkg::REG_HP_B0:        b0_reg      <= cfg_wdata[CW-2:0];
                hngc_pkg::REG_HP_A1:        a1_reg      <= cfg_wdata[CW-1:0];
                hngc_pkg::REG_HP_A2:        a2_reg      <= cfg_wdata[CW-1:0];
                hngc_pkg::REG_ATTACK:
                    attack_reg <= cfg_wdata[hngc_pkg::WEIGHT_W-1:0];
                hngc_pkg::REG_RELEASE:
                    release_reg <= cfg_wdata[hngc_pkg::WEIGHT_W-1:0];
                hngc_pkg::REG_THRESHOLD:    thr_reg     <= cfg_wdata[SW-2:0];
                hngc_pkg::REG_THRESH_RECIP:
                    recip_reg <= cfg_wdata[hngc_pkg::RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier operand select
    always_comb begin
        case (ctrl.word.a_sel)
            hngc_pkg::A_B0:     mul_a = AW'(b0_reg);
            hngc_pkg::A_B0X2:   mul_a = AW'({b0_reg, 1'b0});
            hngc_pkg::A_A1:     mul_a = AW'(a1_reg);
            hngc_pkg::A_A2:     mul_a = AW'(a2_reg);
            hngc_pkg::A_WEIGHT: mul_a = AW'(rise_reg ? attack_reg : release_reg);
            hngc_pkg::A_RECIP:  mul_a = AW'(recip_reg);
            hngc_pkg::A_RATIO:  mul_a = AW'(ratio_reg);
            default:            mul_a = '0;
        endcase
        case (ctrl.word.b_sel)
            hngc_pkg::B_X:     mul_b = BW'(x_reg);
            hngc_pkg::B_P1:    mul_b = BW'(p1_reg);
            hngc_pkg::B_P2:    mul_b = BW'(p2_reg);
            hngc_pkg::B_O1:    mul_b = BW'(o1_reg);
            hngc_pkg::B_O2:    mul_b = BW'(o2_reg);
            hngc_pkg::B_DIFF:  mul_b = BW'(diff_reg);
            hngc_pkg::B_ENV:   mul_b = BW'(env_reg);
            hngc_pkg::B_RATIO: mul_b = BW'(ratio_reg);
            default:           mul_b = '0;
        endcase
        prod_next = mul_a * mul_b;
    end

    // Per-step arithmetic
    always_comb begin
        acc_prod  = ACC_W'(prod_reg);
        filt_rnd  = acc_reg + FILT_HALF;
        filt_sh   = filt_rnd >>> FRAC_C;
        filt_y    = sat_fn(PW'(filt_sh));

        x_bits    = x_reg;
        mag       = x_reg[SW-1] ? (~x_bits + 1'b1) : x_bits;
        mag_above = mag > env_reg;

        prod_half = prod_reg + HALF16;
        env_step  = prod_half[hngc_pkg::GAIN_FRAC +: SW];

        ratio_rnd = prod_reg + RATIO_HALF;
        ratio_sh  = ratio_rnd >>> FRAC_S;
        ratio_val = (ratio_sh > RATIO_CAP) ? hngc_pkg::RATIO_ONE : ratio_sh[RW-1:0];

        scale_sh  = prod_half >>> hngc_pkg::GAIN_FRAC;
    end

    always_comb begin
        x_next      = x_reg;
        acc_next    = acc_reg;
        diff_next   = diff_reg;
        rise_next   = rise_reg;
        ratio_next  = ratio_reg;
        active_next = active_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        o1_next     = o1_reg;
        o2_next     = o2_reg;
        env_next    = env_reg;
        if (start) begin
            x_next      = sample_in;
            active_next = 1'b0;
        end else if (ctrl.run) begin
            case (ctrl.word.acc_op)
                hngc_pkg::ACC_HOLD: acc_next = acc_reg;
                hngc_pkg::ACC_LOAD: acc_next = acc_prod;
                hngc_pkg::ACC_ADD:  acc_next = acc_reg + acc_prod;
                hngc_pkg::ACC_SUB:  acc_next = acc_reg - acc_prod;
                default:            acc_next = acc_reg;
            endcase
            unique case (ctrl.word.dp_op)
                hngc_pkg::OP_NONE: ;
                hngc_pkg::OP_FILT_WB: begin
                    p2_next = p1_reg;
                    p1_next = x_reg;
                    o2_next = o1_reg;
                    o1_next = filt_y;
                    x_next  = filt_y;
                end
                hngc_pkg::OP_DIFF: begin
                    rise_next = mag_above;
                    diff_next = mag_above ? (mag - env_reg) : (env_reg - mag);
                end
                hngc_pkg::OP_ENV: begin
                    env_next = rise_reg ? (env_reg + env_step) : (env_reg - env_step);
                end
                hngc_pkg::OP_RATIO: begin
                    ratio_next  = ratio_val;
                    active_next = 1'b1;
                end
                hngc_pkg::OP_GAIN: begin
                    ratio_next = prod_half[hngc_pkg::GAIN_FRAC +: RW];
                end
                hngc_pkg::OP_SCALE: begin
                    x_next = sat_fn(scale_sh);
                end
                hngc_pkg::OP_OUT: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg  <= '0;
            p2_reg  <= '0;
            o1_reg  <= '0;
            o2_reg  <= '0;
            env_reg <= '0;
        end else begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            o1_reg  <= o1_next;
            o2_reg  <= o2_next;
            env_reg <= env_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        diff_reg   <= diff_next;
        rise_reg   <= rise_next;
        ratio_reg  <= ratio_next;
        active_reg <= active_next;
    end

    assign flags.hp_en     = enables_reg[hngc_pkg::HP_BIT];
    assign flags.gate_en   = enables_reg[hngc_pkg::GATE_BIT];
    assign flags.env_below = env_reg < {1'b0, thr_reg};
    assign sample          = x_reg;
    assign active          = active_reg;

endmodule

FILE: design/highpass_noise_gate_chain.sv
// Top level of the high-pass / noise-gate chain: handshake, output register.
// Depends on hngc_pkg, hngc_seq and hngc_dp.
//
// One signed sample beat in gives one result beat out. Stage one is a
// direct-form-I high-pass biquad (numerator b0, -2*b0, b0; feedback a1, a2)
// whose output saturates to the sample width and is kept saturated as
// history. Stage two is a noise gate: an envelope follows the absolute
// sample (attack weight when rising, release weight otherwise) and, while the
// envelope is below the threshold, the sample is scaled by the square of
// envelope/threshold formed with the reciprocal register and capped at 1.0.
// Either stage is bypassed by its bit in stage_enables; a bypassed stage holds
// its state. All arithmetic runs on one shared multiplier stepped by a
// 17-step program ROM. The steps of a bypassed stage, and the ratio, gain
// and scale steps while the gate stays open, are jumped over. A new sample
// is accepted only after the previous one has left the program. The result
// lands in an output register; the next sample is taken while that beat
// still waits on m_ready, and the program only holds on its final step if
// the previous beat has not yet left. Write configuration only while no
// sample is in flight.
module highpass_noise_gate_chain #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_sample_in,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_sample_out,
    output logic                              m_gate_active,

    input  logic                              cfg_wr_en,
    input  logic [hngc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hngc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    hngc_pkg::ctrl_t               ctrl;
    hngc_pkg::flags_t              flags;
    logic                          seq_idle;
    logic                          start;
    logic                          out_free;
    logic                          out_load;
    logic signed [SAMPLE_WIDTH-1:0] dp_sample;
    logic                          dp_active;

    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_sample_reg;
    logic                          m_active_reg;

    // Take a new beat whenever the sequencer has no sample in flight.
    assign s_ready  = seq_idle;
    assign start    = s_valid && s_ready;

    // The output register is free if empty or draining this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ctrl.run && (ctrl.word.dp_op == hngc_pkg::OP_OUT);

    hngc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_free (out_free),
        .flags    (flags),
        .ctrl     (ctrl),
        .idle     (seq_idle)
    );

    hngc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .sample_in (s_sample_in),
        .ctrl      (ctrl),
        .flags     (flags),
        .sample    (dp_sample),
        .active    (dp_active)
    );

    // Output beat: load on the final program step, drop when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sample_reg <= dp_sample;
            m_active_reg <= dp_active;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_out  = m_sample_reg;
    assign m_gate_active = m_active_reg;

`ifndef NO_ASSERTIONS
    a_load_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over a pending output beat");

    a_idle_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> s_ready)
        else $error("sequencer not idle after delivering a result");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(out_load))
        else $error("output beat raised without a program result");
`endif

endmodule
